// ===== hdl/tbcf_pkg.sv =====
package tbcf_pkg;

    // polygon store per bank and its index and count widths
    localparam int POLY_DEPTH = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int MAX_TRIS   = 7;
    localparam int LAST_PLANE = 5;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MAX_X = 3'd1;
    localparam logic [2:0] REG_MIN_Y = 3'd2;
    localparam logic [2:0] REG_MAX_Y = 3'd3;
    localparam logic [2:0] REG_MIN_Z = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    // clip engine sequencer
    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_LOAD  = 15'h0002,
        S_PLAST = 15'h0004,
        S_PPREV = 15'h0008,
        S_RD    = 15'h0010,
        S_EVAL  = 15'h0020,
        S_MUL   = 15'h0040,
        S_DIV   = 15'h0080,
        S_WRX   = 15'h0100,
        S_WRC   = 15'h0200,
        S_NEXT  = 15'h0400,
        S_EA    = 15'h0800,
        S_EB    = 15'h1000,
        S_EC    = 15'h2000,
        S_EOUT  = 15'h4000
    } t_state;

    // classifier to queue
    typedef struct packed {
        logic push;
        logic in_box;
    } t_cls;

    // queue head to clip engine
    typedef struct packed {
        logic valid;
        logic in_box;
    } t_qctl;

endpackage

// ===== hdl/tbcf_front.sv =====
module tbcf_front #(
    parameter int W = 32
) (
    input  logic [9*W-1:0] i_tri,
    input  logic [6*W-1:0] i_box,
    input  logic           i_start,
    input  logic           i_full,
    output tbcf_pkg::t_cls o_cls
);

    logic [5:0][2:0] w_out;
    logic            w_reject;

    // per plane, per vertex: vertex lies outside the plane
    always_comb begin
        for (int p = 0; p < 6; p++) begin
            for (int v = 0; v < 3; v++) begin
                if (p[0] == 1'b0) begin
                    w_out[p][v] = $signed(i_tri[(v*3 + (p >> 1))*W +: W])
                                < $signed(i_box[p*W +: W]);
                end else begin
                    w_out[p][v] = $signed(i_tri[(v*3 + (p >> 1))*W +: W])
                                > $signed(i_box[p*W +: W]);
                end
            end
        end
    end

    // whole triangle outside one plane gives nothing, so drop it here
    always_comb begin
        w_reject = 1'b0;
        for (int p = 0; p < 6; p++) begin
            w_reject = w_reject | (&w_out[p]);
        end
    end

    assign o_cls.push   = i_start & ~i_full & ~w_reject;
    assign o_cls.in_box = ~(|w_out);

endmodule

// ===== hdl/tbcf_queue.sv =====
module tbcf_queue #(
    parameter int W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tbcf_pkg::t_cls   i_cls,
    input  logic [9*W-1:0]   i_data,
    input  logic             i_pop,
    output logic             o_full,
    output tbcf_pkg::t_qctl  o_ctl,
    output logic [9*W-1:0]   o_data
);

    logic [9*W-1:0] r_data [2];
    logic [1:0]     r_inside;
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    // two-entry triangle queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_cls.push) begin
                r_data[r_wp]   <= i_data;
                r_inside[r_wp] <= i_cls.in_box;
                r_wp           <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_cls.push} - {1'b0, i_pop};
        end
    end

    assign o_full       = r_cnt[1];
    assign o_ctl.valid  = r_cnt != 2'd0;
    assign o_ctl.in_box = r_inside[r_rp];
    assign o_data       = r_data[r_rp];

endmodule

// ===== hdl/tbcf_div.sv =====
module tbcf_div #(
    parameter int W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [2*W-1:0] i_num,
    input  logic [W:0]     i_den,
    output logic [W-1:0]   o_q,
    output logic           o_done
);

    localparam int CW = $clog2(W + 1);

    logic [W:0]   r_rem;
    logic [W-1:0] r_lo;
    logic [W-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [W+1:0] w_t;
    logic [W+1:0] w_sub;
    logic         w_ge;

    // one quotient bit per cycle; the high half is already below the divisor
    assign w_t   = {r_rem, r_lo[W-1]};
    assign w_ge  = w_t >= {1'b0, i_den};
    assign w_sub = w_t - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num[2*W-1:W]};
                r_lo   <= i_num[W-1:0];
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[W:0] : w_t[W:0];
                r_lo  <= {r_lo[W-2:0], 1'b0};
                r_q   <= {r_q[W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

// ===== hdl/tbcf_clip.sv =====
module tbcf_clip #(
    parameter int W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tbcf_pkg::t_qctl i_ctl,
    input  logic [9*W-1:0]  i_tri,
    input  logic [6*W-1:0]  i_box,
    output logic            o_pop,
    output logic            o_vld,
    output logic [9*W-1:0]  o_tri,
    output logic            o_last
);

    localparam int VW = 3*W;
    localparam int AW = tbcf_pkg::IDX_W + 1;
    localparam int IW = tbcf_pkg::IDX_W;
    localparam int NW = tbcf_pkg::CNT_W;

    tbcf_pkg::t_state r_state;
    tbcf_pkg::t_state n_state;

    logic [9*W-1:0] r_tri;
    logic           r_inside;
    logic           r_bank;
    logic [2:0]     r_plane;
    logic [NW-1:0]  r_n;
    logic [NW-1:0]  r_out;
    logic [NW-1:0]  r_i;
    logic [VW-1:0]  r_prev;
    logic [VW-1:0]  r_cur;
    logic           r_pneg;
    logic           r_cneg;
    logic [W-1:0]   r_pmag;
    logic [W-1:0]   r_cmag;
    logic [2*W-1:0] r_prod [3];
    logic [W:0]     r_den;
    logic           r_dstart;
    logic [2:0]     r_t;
    logic [2:0]     r_tris;
    logic [VW-1:0]  r_apex;
    logic [VW-1:0]  r_vb;
    logic           r_ovld;
    logic [9*W-1:0] r_otri;
    logic           r_olast;

    logic [VW-1:0]  mem [2*tbcf_pkg::POLY_DEPTH];
    logic [VW-1:0]  r_rdat;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [VW-1:0]  w_wdat;
    logic [AW-1:0]  w_raddr;

    logic [W-1:0]   w_q [3];
    logic [2:0]     w_ddone;
    logic [W:0]     w_cd;
    logic [W-1:0]   w_bnd;
    logic [VW-1:0]  w_cross;
    logic [NW-1:0]  w_inext;
    logic [NW-1:0]  w_nm1;
    logic [NW-1:0]  w_tm2;
    logic           w_room;

    // signed distance to a plane as {outside, magnitude}
    function automatic logic [W:0] f_dist(input logic [W-1:0] x, input logic [W-1:0] b,
                                          input logic keep_ge);
        logic [W:0] d;
        logic [W:0] m;
        logic       neg;
        d   = {x[W-1], x} - {b[W-1], b};
        neg = keep_ge ? d[W] : (~d[W] && (d != '0));
        m   = d[W] ? (~d + 1'b1) : d;
        return {neg, m[W-1:0]};
    endfunction

    function automatic logic [W-1:0] f_absdiff(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] d;
        logic [W:0] m;
        d = {a[W-1], a} - {b[W-1], b};
        m = d[W] ? (~d + 1'b1) : d;
        return m[W-1:0];
    endfunction

    assign w_bnd   = i_box[r_plane*W +: W];
    assign w_cd    = f_dist(r_rdat[r_plane[2:1]*W +: W], w_bnd, ~r_plane[0]);
    assign w_inext = r_i + 1'b1;
    assign w_nm1   = r_n - 1'b1;
    assign w_tm2   = r_n - NW'(2);
    assign w_room  = r_out < NW'(tbcf_pkg::POLY_DEPTH);

    // edge crossing point, per axis stepped from prev toward cur
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if ($signed(r_cur[k*W +: W]) >= $signed(r_prev[k*W +: W])) begin
                w_cross[k*W +: W] = r_prev[k*W +: W] + w_q[k];
            end else begin
                w_cross[k*W +: W] = r_prev[k*W +: W] - w_q[k];
            end
        end
    end

    // one divider per axis, sharing the denominator
    for (genvar k = 0; k < 3; k++) begin : g_div
        tbcf_div #(.W(W)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_dstart),
            .i_num   (r_prod[k]),
            .i_den   (r_den),
            .o_q     (w_q[k]),
            .o_done  (w_ddone[k])
        );
    end

    // polygon store write and read addressing
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {~r_bank, r_out[IW-1:0]};
        w_wdat  = r_cur;
        w_raddr = {r_bank, r_i[IW-1:0]};
        case (r_state)
            tbcf_pkg::S_LOAD: begin
                w_we    = 1'b1;
                w_waddr = {1'b0, r_i[IW-1:0]};
                w_wdat  = r_tri[r_i[1:0]*VW +: VW];
            end
            tbcf_pkg::S_WRX: begin
                w_we   = w_room;
                w_wdat = w_cross;
            end
            tbcf_pkg::S_WRC: begin
                w_we = w_room;
            end
            tbcf_pkg::S_PLAST: begin
                w_raddr = {r_bank, w_nm1[IW-1:0]};
            end
            tbcf_pkg::S_EA: begin
                w_raddr = {r_bank, IW'(0)};
            end
            tbcf_pkg::S_EB: begin
                w_raddr = {r_bank, IW'(1)};
            end
            tbcf_pkg::S_EC: begin
                w_raddr = {r_bank, IW'(2)};
            end
            tbcf_pkg::S_EOUT: begin
                w_raddr = {r_bank, IW'(r_t) + IW'(3)};
            end
            default: begin
                w_raddr = {r_bank, r_i[IW-1:0]};
            end
        endcase
    end

    // ping-pong polygon memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdat;
        end
        r_rdat <= mem[w_raddr];
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbcf_pkg::S_IDLE: begin
                if (i_ctl.valid) n_state = tbcf_pkg::S_LOAD;
            end
            tbcf_pkg::S_LOAD: begin
                if (r_i == NW'(2)) begin
                    n_state = r_inside ? tbcf_pkg::S_EA : tbcf_pkg::S_PLAST;
                end
            end
            tbcf_pkg::S_PLAST: n_state = tbcf_pkg::S_PPREV;
            tbcf_pkg::S_PPREV: n_state = tbcf_pkg::S_RD;
            tbcf_pkg::S_RD:    n_state = tbcf_pkg::S_EVAL;
            tbcf_pkg::S_EVAL: begin
                if (r_pneg != w_cd[W])   n_state = tbcf_pkg::S_MUL;
                else if (!w_cd[W])       n_state = tbcf_pkg::S_WRC;
                else                     n_state = tbcf_pkg::S_NEXT;
            end
            tbcf_pkg::S_MUL: n_state = tbcf_pkg::S_DIV;
            tbcf_pkg::S_DIV: begin
                if (w_ddone[0]) n_state = tbcf_pkg::S_WRX;
            end
            tbcf_pkg::S_WRX: n_state = r_cneg ? tbcf_pkg::S_NEXT : tbcf_pkg::S_WRC;
            tbcf_pkg::S_WRC: n_state = tbcf_pkg::S_NEXT;
            tbcf_pkg::S_NEXT: begin
                if (w_inext == r_n) begin
                    if (r_out < NW'(3))                    n_state = tbcf_pkg::S_IDLE;
                    else if (r_plane == 3'(tbcf_pkg::LAST_PLANE)) n_state = tbcf_pkg::S_EA;
                    else                                   n_state = tbcf_pkg::S_PLAST;
                end else begin
                    n_state = tbcf_pkg::S_RD;
                end
            end
            tbcf_pkg::S_EA: n_state = tbcf_pkg::S_EB;
            tbcf_pkg::S_EB: n_state = tbcf_pkg::S_EC;
            tbcf_pkg::S_EC: n_state = tbcf_pkg::S_EOUT;
            tbcf_pkg::S_EOUT: begin
                if (r_t == r_tris - 1'b1) n_state = tbcf_pkg::S_IDLE;
            end
            default: n_state = tbcf_pkg::S_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tbcf_pkg::S_IDLE;
            r_dstart <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dstart <= r_state == tbcf_pkg::S_MUL;
            r_ovld   <= 1'b0;
            case (r_state)
                tbcf_pkg::S_IDLE: begin
                    r_tri    <= i_tri;
                    r_inside <= i_ctl.in_box;
                    r_i      <= '0;
                end
                tbcf_pkg::S_LOAD: begin
                    r_i <= w_inext;
                    if (r_i == NW'(2)) begin
                        r_bank  <= 1'b0;
                        r_n     <= NW'(3);
                        r_out   <= '0;
                        r_plane <= '0;
                    end
                end
                tbcf_pkg::S_PPREV: begin
                    r_prev <= r_rdat;
                    r_pneg <= w_cd[W];
                    r_pmag <= w_cd[W-1:0];
                    r_i    <= '0;
                end
                tbcf_pkg::S_EVAL: begin
                    r_cur  <= r_rdat;
                    r_cneg <= w_cd[W];
                    r_cmag <= w_cd[W-1:0];
                end
                tbcf_pkg::S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_prod[k] <= (2*W)'(f_absdiff(r_cur[k*W +: W], r_prev[k*W +: W]))
                                   * (2*W)'(r_pmag);
                    end
                    r_den <= {1'b0, r_pmag} + {1'b0, r_cmag};
                end
                tbcf_pkg::S_WRX, tbcf_pkg::S_WRC: begin
                    if (w_room) r_out <= r_out + 1'b1;
                end
                tbcf_pkg::S_NEXT: begin
                    r_prev <= r_cur;
                    r_pneg <= r_cneg;
                    r_pmag <= r_cmag;
                    r_i    <= w_inext;
                    if (w_inext == r_n && r_out >= NW'(3)) begin
                        r_bank  <= ~r_bank;
                        r_n     <= r_out;
                        r_out   <= '0;
                        r_plane <= r_plane + 1'b1;
                    end
                end
                tbcf_pkg::S_EA: begin
                    r_t    <= '0;
                    r_tris <= (w_tm2 > NW'(tbcf_pkg::MAX_TRIS)) ? 3'(tbcf_pkg::MAX_TRIS)
                                                                : w_tm2[2:0];
                end
                tbcf_pkg::S_EB: begin
                    r_apex <= r_rdat;
                end
                tbcf_pkg::S_EC: begin
                    r_vb <= r_rdat;
                end
                tbcf_pkg::S_EOUT: begin
                    r_ovld  <= 1'b1;
                    r_otri  <= {r_rdat, r_vb, r_apex};
                    r_olast <= r_t == r_tris - 1'b1;
                    r_vb    <= r_rdat;
                    r_t     <= r_t + 1'b1;
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

    assign o_pop  = (r_state == tbcf_pkg::S_IDLE) && i_ctl.valid;
    assign o_vld  = r_ovld;
    assign o_tri  = r_otri;
    assign o_last = r_olast;

endmodule

// ===== hdl/triangle_box_clip_fan_top.sv =====
// Clips a triangle against the configured box (min x, max x, min y, max y, min z,
// max z planes in that order) and fans what is left into up to seven triangles,
// one per cycle on the result ports while o_strobe is high; the receiver cannot
// stall, so each result must be taken in the cycle it appears, and
// o_last_triangle marks the final one. Triangles wholly outside one plane are
// dropped at the input and produce nothing. Every other triangle is loaded into
// the polygon store; one wholly inside skips clipping and goes straight to the
// fan, while the rest are clipped against each plane in turn, with bit-serial
// dividers computing every edge crossing, and then fanned. A two-triangle queue
// sits in front of the clip engine; busy is high while it is full. Write the box
// only while the block is idle.
module triangle_box_clip_fan_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0] i_cfg_data,
    input  logic [COORD_WIDTH-1:0] i_in_a_x,
    input  logic [COORD_WIDTH-1:0] i_in_a_y,
    input  logic [COORD_WIDTH-1:0] i_in_a_z,
    input  logic [COORD_WIDTH-1:0] i_in_b_x,
    input  logic [COORD_WIDTH-1:0] i_in_b_y,
    input  logic [COORD_WIDTH-1:0] i_in_b_z,
    input  logic [COORD_WIDTH-1:0] i_in_c_x,
    input  logic [COORD_WIDTH-1:0] i_in_c_y,
    input  logic [COORD_WIDTH-1:0] i_in_c_z,
    output logic                   o_strobe,
    output logic [COORD_WIDTH-1:0] o_out_a_x,
    output logic [COORD_WIDTH-1:0] o_out_a_y,
    output logic [COORD_WIDTH-1:0] o_out_a_z,
    output logic [COORD_WIDTH-1:0] o_out_b_x,
    output logic [COORD_WIDTH-1:0] o_out_b_y,
    output logic [COORD_WIDTH-1:0] o_out_b_z,
    output logic [COORD_WIDTH-1:0] o_out_c_x,
    output logic [COORD_WIDTH-1:0] o_out_c_y,
    output logic [COORD_WIDTH-1:0] o_out_c_z,
    output logic                   o_last_triangle
);

    localparam int W = COORD_WIDTH;

    logic [6*W-1:0]   r_box;
    logic [9*W-1:0]   w_tri;
    logic [9*W-1:0]   w_qdata;
    logic [9*W-1:0]   w_otri;
    tbcf_pkg::t_cls   w_cls;
    tbcf_pkg::t_qctl  w_qctl;
    logic             w_full;
    logic             w_pop;

    assign w_tri = {i_in_c_z, i_in_c_y, i_in_c_x, i_in_b_z, i_in_b_y, i_in_b_x,
                    i_in_a_z, i_in_a_y, i_in_a_x};

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbcf_pkg::REG_MIN_X: r_box[0*W +: W] <= i_cfg_data;
                tbcf_pkg::REG_MAX_X: r_box[1*W +: W] <= i_cfg_data;
                tbcf_pkg::REG_MIN_Y: r_box[2*W +: W] <= i_cfg_data;
                tbcf_pkg::REG_MAX_Y: r_box[3*W +: W] <= i_cfg_data;
                tbcf_pkg::REG_MIN_Z: r_box[4*W +: W] <= i_cfg_data;
                tbcf_pkg::REG_MAX_Z: r_box[5*W +: W] <= i_cfg_data;
                default: r_box <= r_box;
            endcase
        end
    end

    tbcf_front #(.W(W)) u_front (
        .i_tri   (w_tri),
        .i_box   (r_box),
        .i_start (start),
        .i_full  (w_full),
        .o_cls   (w_cls)
    );

    tbcf_queue #(.W(W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cls   (w_cls),
        .i_data  (w_tri),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_ctl   (w_qctl),
        .o_data  (w_qdata)
    );

    tbcf_clip #(.W(W)) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_tri   (w_qdata),
        .i_box   (r_box),
        .o_pop   (w_pop),
        .o_vld   (o_strobe),
        .o_tri   (w_otri),
        .o_last  (o_last_triangle)
    );

    assign busy      = w_full;
    assign o_out_a_x = w_otri[0*W +: W];
    assign o_out_a_y = w_otri[1*W +: W];
    assign o_out_a_z = w_otri[2*W +: W];
    assign o_out_b_x = w_otri[3*W +: W];
    assign o_out_b_y = w_otri[4*W +: W];
    assign o_out_b_z = w_otri[5*W +: W];
    assign o_out_c_x = w_otri[6*W +: W];
    assign o_out_c_y = w_otri[7*W +: W];
    assign o_out_c_z = w_otri[8*W +: W];

endmodule
